// ===== src/sawdr_pkg.sv =====
`timescale 1ns / 1ps

package sawdr_pkg;

  localparam int MAX_PAYLOAD  = 1024;
  localparam int HEADER_BYTES = 5;
  localparam int LEN_W        = 11;
  localparam int IDX_W        = 11;
  localparam int OQ_DEPTH     = 4;
  localparam int OQ_PTR_W     = $clog2(OQ_DEPTH);
  localparam int OQ_CNT_W     = $clog2(OQ_DEPTH + 1);

  // Header byte positions.
  localparam logic [IDX_W-1:0] IDX_CHK_HI = 11'd0;
  localparam logic [IDX_W-1:0] IDX_CHK_LO = 11'd1;
  localparam logic [IDX_W-1:0] IDX_FLAGS  = 11'd2;
  localparam logic [IDX_W-1:0] IDX_LEN_LO = 11'd3;
  localparam logic [IDX_W-1:0] IDX_SEQ    = 11'd4;
  localparam logic [IDX_W-1:0] IDX_HDR    = 11'(HEADER_BYTES);
  localparam logic [IDX_W-1:0] IDX_MAX    = '1;

  // Flags codes, received and sent.
  localparam logic [7:0] FL_ACK_SYN  = 8'd96;
  localparam logic [7:0] FL_SYN      = 8'd32;
  localparam logic [7:0] FL_ACK_NAME = 8'd192;
  localparam logic [7:0] FL_NAK_NAME = 8'd128;
  localparam logic [7:0] FL_FIN      = 8'd16;
  localparam logic [7:0] FL_ACK_FIN  = 8'd80;
  localparam logic [7:0] FL_FEND     = 8'd8;
  localparam logic [7:0] FL_ACK_FEND = 8'd72;
  localparam logic [7:0] FL_ACK      = 8'd64;
  localparam int         FL_NAME_BIT = 7;

  localparam logic [15:0] SUM_GOOD = '1;

  // Summary of a finished datagram, handed from the parser to the reply logic.
  typedef struct packed {
    logic             valid;
    logic [7:0]       flags;
    logic [7:0]       seq;
    logic [LEN_W-1:0] len;
    logic             pass;
  } dgram_t;

  typedef struct packed {
    logic [7:0]       reply_flags;
    logic [7:0]       reply_seq;
    logic             commit_payload;
    logic [LEN_W-1:0] payload_length;
    logic             run_last;
  } res_t;

  function automatic logic [LEN_W-1:0] decode_len(logic [7:0] flags, logic [7:0] low);
    logic [LEN_W-1:0] n;
    n = {1'b0, flags[1:0], low};
    if (n == '0 && flags[7:3] == '0) begin
      n = LEN_W'(1024);
    end
    if (n > LEN_W'(MAX_PAYLOAD)) begin
      n = LEN_W'(MAX_PAYLOAD);
    end
    return n;
  endfunction

  function automatic logic [15:0] add_wrap(logic [15:0] s, logic [7:0] b);
    logic [16:0] t;
    t = {1'b0, s} + {9'b0, b};
    if (t[16]) begin
      t[15:0] = t[15:0] + 16'd1;
    end
    return t[15:0];
  endfunction

endpackage

// ===== src/sawdr_parse.sv =====
`timescale 1ns / 1ps

// Header capture and running end-around-carry sum over one datagram.
module sawdr_parse import sawdr_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  input  logic       closed,
  output dgram_t     dg
);

  logic [IDX_W-1:0] byte_index_r, byte_index_nxt;
  logic [15:0]      sum_r, sum_nxt;
  logic [15:0]      check_r, check_nxt;
  logic [7:0]       flags_r, flags_nxt;
  logic [7:0]       len_lo_r, len_lo_nxt;
  logic [7:0]       seq_r, seq_nxt;
  logic [LEN_W-1:0] len_cur;
  logic [15:0]      total;
  logic             live;

  assign live = step && !closed;

  always_comb begin
    check_nxt  = check_r;
    flags_nxt  = flags_r;
    len_lo_nxt = len_lo_r;
    seq_nxt    = seq_r;
    sum_nxt    = sum_r;
    case (byte_index_r)
      IDX_CHK_HI: check_nxt[15:8] = in_byte;
      IDX_CHK_LO: check_nxt[7:0]  = in_byte;
      IDX_FLAGS:  flags_nxt       = in_byte;
      IDX_LEN_LO: len_lo_nxt      = in_byte;
      IDX_SEQ:    seq_nxt         = in_byte;
      default:    ;
    endcase
    len_cur = decode_len(flags_nxt, len_lo_nxt);
    // Bytes from the flags byte up to the end of the declared payload are summed.
    if (byte_index_r >= IDX_FLAGS &&
        (byte_index_r < IDX_HDR || (byte_index_r - IDX_HDR) < len_cur)) begin
      sum_nxt = add_wrap(sum_r, in_byte);
    end
    byte_index_nxt = (byte_index_r == IDX_MAX) ? byte_index_r : byte_index_r + 11'd1;
  end

  // Check bytes are added in plain 16-bit arithmetic.
  assign total    = sum_nxt + check_nxt;
  assign dg.valid = live && in_last;
  assign dg.flags = flags_nxt;
  assign dg.seq   = seq_nxt;
  assign dg.len   = len_cur;
  assign dg.pass  = (total == SUM_GOOD);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_index_r <= '0;
      sum_r        <= '0;
      check_r      <= '0;
      flags_r      <= '0;
      len_lo_r     <= '0;
      seq_r        <= '0;
    end else if (live) begin
      if (in_last) begin
        byte_index_r <= '0;
        sum_r        <= '0;
        check_r      <= '0;
        flags_r      <= '0;
        len_lo_r     <= '0;
        seq_r        <= '0;
      end else begin
        byte_index_r <= byte_index_nxt;
        sum_r        <= sum_nxt;
        check_r      <= check_nxt;
        flags_r      <= flags_nxt;
        len_lo_r     <= len_lo_nxt;
        seq_r        <= seq_nxt;
      end
    end
  end

endmodule

// ===== src/sawdr_reply.sv =====
`timescale 1ns / 1ps

// Session state and reply decision for a finished datagram.
module sawdr_reply import sawdr_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  dgram_t     dg,
  output res_t       res0,
  output res_t       res1,
  output logic [1:0] wr_cnt,
  output logic       closed
);

  logic [7:0] last_acc_r, last_acc_nxt;
  logic [7:0] held_seq_r, held_seq_nxt;
  logic       name_seen_r, name_seen_nxt;
  logic       file_open_r, file_open_nxt;
  logic       closed_r, closed_nxt;
  logic [7:0] expect_seq;
  logic [7:0] seq_inc;
  logic [1:0] n;

  assign expect_seq = last_acc_r + 8'd1;
  assign seq_inc    = dg.seq + 8'd1;

  always_comb begin
    last_acc_nxt  = last_acc_r;
    held_seq_nxt  = held_seq_r;
    name_seen_nxt = name_seen_r;
    file_open_nxt = file_open_r;
    closed_nxt    = closed_r;
    n             = 2'd0;
    res0          = '{reply_flags: FL_ACK, reply_seq: held_seq_r, commit_payload: 1'b0,
                      payload_length: dg.len, run_last: 1'b1};
    res1          = '{reply_flags: FL_FIN, reply_seq: held_seq_r, commit_payload: 1'b0,
                      payload_length: dg.len, run_last: 1'b1};
    if (dg.valid) begin
      if (dg.flags == FL_ACK_SYN) begin
        n = 2'd0;
      end else if (dg.flags == FL_SYN) begin
        n = 2'd1;
        res0.reply_flags = FL_ACK_SYN;
      end else if (dg.flags[FL_NAME_BIT]) begin
        n = 2'd1;
        if (dg.pass) begin
          res0.reply_flags = FL_ACK_NAME;
          name_seen_nxt    = 1'b1;
          file_open_nxt    = 1'b1;
        end else begin
          res0.reply_flags = FL_NAK_NAME;
        end
      end else if (dg.flags == FL_FIN) begin
        n                = 2'd2;
        res0.reply_flags = FL_ACK_FIN;
        res0.run_last    = 1'b0;
        closed_nxt       = 1'b1;
      end else if (dg.flags == FL_FEND) begin
        if (name_seen_r) begin
          n                = 2'd1;
          res0.reply_flags = FL_ACK_FEND;
          file_open_nxt    = 1'b0;
        end
      end else if (dg.pass) begin
        n = 2'd1;
        if (dg.seq == expect_seq) begin
          last_acc_nxt        = dg.seq;
          held_seq_nxt        = seq_inc;
          res0.reply_seq      = seq_inc;
          res0.commit_payload = file_open_r;
        end else begin
          held_seq_nxt   = expect_seq;
          res0.reply_seq = expect_seq;
        end
      end
    end
  end

  assign wr_cnt = n;
  assign closed = closed_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_acc_r  <= 8'hFF;
      held_seq_r  <= '0;
      name_seen_r <= 1'b0;
      file_open_r <= 1'b0;
      closed_r    <= 1'b0;
    end else begin
      last_acc_r  <= last_acc_nxt;
      held_seq_r  <= held_seq_nxt;
      name_seen_r <= name_seen_nxt;
      file_open_r <= file_open_nxt;
      closed_r    <= closed_nxt;
    end
  end

endmodule

// ===== src/sawdr_outq.sv =====
`timescale 1ns / 1ps

// Small reply queue: takes up to two replies a cycle, gives one per beat.
module sawdr_outq import sawdr_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [1:0] wr_cnt,
  input  res_t       res0,
  input  res_t       res1,
  output logic       space_ok,
  output logic       out_valid,
  input  logic       out_ready,
  output res_t       out_res
);

  res_t                entry_r [OQ_DEPTH];
  logic [OQ_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [OQ_PTR_W-1:0] wr_ptr_p1;
  logic [OQ_CNT_W-1:0] count_r;
  logic                rd_en;

  assign wr_ptr_p1 = wr_ptr_r + 1'b1;
  assign out_valid = (count_r != '0);
  assign out_res   = entry_r[rd_ptr_r];
  assign rd_en     = out_valid && out_ready;
  assign space_ok  = (count_r <= OQ_CNT_W'(OQ_DEPTH - 2));

  always_ff @(posedge clk) begin
    if (wr_cnt != 2'd0) begin
      entry_r[wr_ptr_r] <= res0;
    end
    if (wr_cnt == 2'd2) begin
      entry_r[wr_ptr_p1] <= res1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + OQ_PTR_W'(wr_cnt);
      if (rd_en) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_r + OQ_CNT_W'(wr_cnt) - OQ_CNT_W'(rd_en);
    end
  end

endmodule

// ===== src/stop_and_wait_datagram_receiver_top.sv =====
`timescale 1ns / 1ps

// A byte in the input register is processed once the queue has room for two replies: it is
// parsed and decided, its replies enter the reply queue, and tvalid rises once one is queued.
// Throughput: one byte per cycle while that room lasts; a datagram gives at most one reply,
// except FIN, which gives two. The queue holds four replies, so input flows while one waits.
// Reset (rst_n low, synchronous) clears the datagram parser, the queue and the session,
// with last accepted sequence at 255 so that sequence zero is expected first.

module stop_and_wait_datagram_receiver_top import sawdr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // Input datagram byte stream.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  logic        in_tlast,   // end_of_datagram
  // Reply stream.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [7:0] reply_flags, [15:8] reply_seq,
                                  // [26:16] payload_length, [31:27] zero
  output logic        out_tuser,  // commit_payload
  output logic        out_tlast   // run_last
);

  // Input register: one byte beat held for the processing stage.
  logic       in_valid_r;
  logic [7:0] in_byte_r;
  logic       in_last_r;

  logic       space_ok;
  logic       proc_fire;
  logic       closed;
  dgram_t     dg;
  res_t       res0, res1, out_res;
  logic [1:0] wr_cnt;

  // The byte in the input register is processed once the queue has room for two replies.
  assign proc_fire = in_valid_r && space_ok;
  assign in_tready = !in_valid_r || space_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata;
      in_last_r <= in_tlast;
    end
  end

  // Header fields and checksum; after the session closes, every byte is dropped.
  sawdr_parse u_parse (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (proc_fire),
    .in_byte (in_byte_r),
    .in_last (in_last_r),
    .closed  (closed),
    .dg      (dg)
  );

  sawdr_reply u_reply (
    .clk    (clk),
    .rst_n  (rst_n),
    .dg     (dg),
    .res0   (res0),
    .res1   (res1),
    .wr_cnt (wr_cnt),
    .closed (closed)
  );

  sawdr_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_cnt    (wr_cnt),
    .res0      (res0),
    .res1      (res1),
    .space_ok  (space_ok),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  assign out_tdata = {5'b0, out_res.payload_length, out_res.reply_seq, out_res.reply_flags};
  assign out_tuser = out_res.commit_payload;
  assign out_tlast = out_res.run_last;

`ifndef SYNTHESIS
  // A closed session writes no replies.
  a_closed_silent: assert property (@(posedge clk) disable iff (!rst_n)
    closed |-> wr_cnt == 2'd0)
    else $error("reply written after session closed");

  // Two replies come only from FIN, which closes the session.
  a_pair_closes: assert property (@(posedge clk) disable iff (!rst_n)
    wr_cnt == 2'd2 |=> closed)
    else $error("reply pair without session close");

  // A byte waiting in the input register stays put until it is processed.
  a_hold_byte: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !proc_fire |=> in_valid_r && $stable(in_byte_r) && $stable(in_last_r))
    else $error("input register lost a byte");

  // Replies are only written when a processed byte ends a datagram.
  a_write_cause: assert property (@(posedge clk) disable iff (!rst_n)
    wr_cnt != 2'd0 |-> proc_fire && in_last_r)
    else $error("reply written without end of datagram");
`endif

endmodule

// ===== verif/sawdr_arq_ledger_pkg.sv =====
`timescale 1ns / 1ps

package sawdr_arq_ledger_pkg;

  import sawdr_pkg::*;

  // Payload length carried by a header: ten bits, with the all-zero case meaning a full
  // buffer unless any type bit is set.
  function automatic logic [LEN_W-1:0] datagram_len(logic [7:0] flags, logic [7:0] low);
    logic [LEN_W-1:0] n;
    n = {1'b0, flags[1:0], low};
    if (n == 0 && flags[7:3] == 5'd0) begin
      n = LEN_W'(MAX_PAYLOAD);
    end
    if (n > LEN_W'(MAX_PAYLOAD)) begin
      n = LEN_W'(MAX_PAYLOAD);
    end
    return n;
  endfunction

  // Ones-complement style accumulate: a carry out of bit 15 wraps back into bit 0.
  function automatic logic [15:0] ones_add(logic [15:0] s, logic [7:0] b);
    logic [16:0] t;
    t = {1'b0, s} + {9'd0, b};
    if (t[16]) begin
      t[15:0] = t[15:0] + 16'd1;
    end
    return t[15:0];
  endfunction

  class arq_reply_ledger;

    res_t due_replies[$];
    res_t batch[$];

    int bytes_seen;
    int datagrams;
    int replies_checked;
    int commits;
    int errors;

    int          pos;
    logic [15:0] chk;
    logic [15:0] run_sum;
    logic [7:0]  flg;
    logic [7:0]  len_lo;
    logic [7:0]  sq;
    logic [7:0]  last_seq;
    logic [7:0]  held_seq;
    bit          name_seen;
    bit          file_open;
    bit          closed;

    function new();
      clear_datagram();
      last_seq  = 8'd255;
      held_seq  = 8'd0;
      name_seen = 0;
      file_open = 0;
      closed    = 0;
    endfunction

    function void clear_datagram();
      pos     = 0;
      chk     = 16'd0;
      run_sum = 16'd0;
      flg     = 8'd0;
      len_lo  = 8'd0;
      sq      = 8'd0;
    endfunction

    function logic [7:0] next_seq();
      return last_seq + 8'd1;
    endfunction

    function void stage(logic [7:0] flags, logic [7:0] seq, logic commit,
                        logic [LEN_W-1:0] len);
      res_t r;
      r.reply_flags    = flags;
      r.reply_seq      = seq;
      r.commit_payload = commit;
      r.payload_length = len;
      r.run_last       = 1'b0;
      batch.insert(batch.size(), r);
    endfunction

    // One accepted input beat: update the parse state and, on the closing beat, queue
    // the replies that the datagram earns.
    function void take_byte(logic [7:0] b, logic eod);
      logic [LEN_W-1:0] n;
      logic [15:0]      total;
      logic [7:0]       want_seq;
      bit               ok;
      bytes_seen++;
      if (closed) begin
        return;
      end
      if (pos == 0) begin
        chk[15:8] = b;
      end else if (pos == 1) begin
        chk[7:0] = b;
      end else begin
        if (pos == 2) begin
          flg = b;
        end else if (pos == 3) begin
          len_lo = b;
        end else if (pos == 4) begin
          sq = b;
        end
        if (pos < HEADER_BYTES || pos - HEADER_BYTES < datagram_len(flg, len_lo)) begin
          run_sum = ones_add(run_sum, b);
        end
      end
      if (pos < 2047) begin
        pos++;
      end
      if (!eod) begin
        return;
      end

      datagrams++;
      n     = datagram_len(flg, len_lo);
      total = run_sum + {chk[15:8], 8'd0} + {8'd0, chk[7:0]};
      ok    = (total == SUM_GOOD);
      batch.delete();
      if (flg == FL_ACK_SYN) begin
      end else if (flg == FL_SYN) begin
        stage(FL_ACK_SYN, held_seq, 1'b0, n);
      end else if (flg[FL_NAME_BIT]) begin
        if (ok) begin
          stage(FL_ACK_NAME, held_seq, 1'b0, n);
          name_seen = 1;
          file_open = 1;
        end else begin
          stage(FL_NAK_NAME, held_seq, 1'b0, n);
        end
      end else if (flg == FL_FIN) begin
        stage(FL_ACK_FIN, held_seq, 1'b0, n);
        stage(FL_FIN, held_seq, 1'b0, n);
        closed = 1;
      end else if (flg == FL_FEND) begin
        if (name_seen) begin
          file_open = 0;
          stage(FL_ACK_FEND, held_seq, 1'b0, n);
        end
      end else if (ok) begin
        want_seq = last_seq + 8'd1;
        if (sq == want_seq) begin
          last_seq = sq;
          held_seq = sq + 8'd1;
          stage(FL_ACK, held_seq, file_open, n);
        end else begin
          held_seq = want_seq;
          stage(FL_ACK, held_seq, 1'b0, n);
        end
      end
      if (batch.size() > 0) begin
        batch[batch.size() - 1].run_last = 1'b1;
      end
      foreach (batch[i]) begin
        due_replies.insert(due_replies.size(), batch[i]);
      end
      clear_datagram();
    endfunction

    function void field_check(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    // One accepted reply beat, compared with the oldest reply still owed.
    function void match_reply(logic [31:0] d, logic user, logic last);
      res_t want;
      if (due_replies.size() == 0) begin
        $error("reply with nothing owed: flags %0d seq %0d", d[7:0], d[15:8]);
        errors++;
        return;
      end
      want = due_replies.pop_front();
      replies_checked++;
      if (want.commit_payload) begin
        commits++;
      end
      field_check("reply_flags", 32'(want.reply_flags), 32'(d[7:0]));
      field_check("reply_seq", 32'(want.reply_seq), 32'(d[15:8]));
      field_check("payload_length", 32'(want.payload_length), 32'(d[26:16]));
      field_check("tdata_pad", 32'd0, 32'(d[31:27]));
      field_check("commit_payload", 32'(want.commit_payload), 32'(user));
      field_check("run_last", 32'(want.run_last), 32'(last));
    endfunction

  endclass

endpackage

// ===== verif/tb_stop_and_wait_datagram_receiver_top.sv =====
`timescale 1ns / 1ps

// Byte-stream test of the stop-and-wait receiver. Datagrams are built with a correct or a
// deliberately broken check word, sent one beat at a time, and every reply beat is compared
// against a running model of the session held in the ledger class.
module tb_stop_and_wait_datagram_receiver_top;

  import sawdr_pkg::*;
  import sawdr_arq_ledger_pkg::*;

  // Plain data type: no type bits set.
  localparam logic [7:0] DATA_PLAIN  = 8'h00;
  localparam int         HOLD_CYCLES = 400;
  localparam int         RANDOM_BYTES = 560;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;

  arq_reply_ledger led;

  // Set by the stimulus to suspend random idling on both sides.
  bit calm;
  // A request from the stimulus; the reply side turns it into a long hold-off of its own.
  bit hold_req;

  stop_and_wait_datagram_receiver_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block wedges.
  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Reply side. Each accepted beat is checked at the edge where it is taken; tready is
  // then redrawn for the next cycle. A hold-off request keeps tready low for a long,
  // counted stretch so the reply queue fills and the block has to stall its input.
  initial begin
    int hold_left;
    hold_left = 0;
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (out_tvalid === 1'b1 && out_tready === 1'b1) begin
        led.match_reply(out_tdata, out_tuser, out_tlast);
      end
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= calm || ($urandom_range(99) >= 36);
      end
    end
  end

  // Offer one beat, idling first at random, and return at the edge where it is taken.
  // The caller always enters at a clock edge, so tvalid gets a single update per step.
  task automatic send_byte(input logic [7:0] b, input logic eod);
    while (!calm && $urandom_range(99) < 36) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= eod;
    @(posedge clk);
    while (in_tready !== 1'b1) begin
      @(posedge clk);
    end
    led.take_byte(b, eod);
  endtask

  // Build one datagram: header, then body bytes (random when fill is negative). The check
  // word is the complement of the covered sum, so it passes unless spoiled. A nonzero keep
  // cuts the datagram short after that many bytes.
  task automatic send_datagram(input logic [7:0] flags, input logic [7:0] len_lo,
                               input logic [7:0] seq, input int body, input int fill,
                               input bit spoil, input int keep);
    logic [7:0]  pkt[$];
    logic [15:0] s;
    logic [15:0] chk;
    int          last_idx;
    pkt = {8'd0, 8'd0, flags, len_lo, seq};
    for (int i = 0; i < body; i++) begin
      pkt.insert(pkt.size(), fill < 0 ? 8'($urandom_range(0, 255)) : 8'(fill));
    end
    s = 16'd0;
    for (int i = 2; i < pkt.size(); i++) begin
      if (i < HEADER_BYTES || i - HEADER_BYTES < datagram_len(flags, len_lo)) begin
        s = ones_add(s, pkt[i]);
      end
    end
    chk = ~s;
    if (spoil) begin
      chk = chk ^ 16'($urandom_range(1, 65535));
    end
    pkt[0] = chk[15:8];
    pkt[1] = chk[7:0];
    last_idx = (keep > 0 && keep < pkt.size()) ? keep - 1 : pkt.size() - 1;
    for (int i = 0; i <= last_idx; i++) begin
      send_byte(pkt[i], i == last_idx);
    end
  endtask

  // Sender pause: drop tvalid and wait until every owed reply has come back.
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (led.due_replies.size() != 0) begin
      @(posedge clk);
    end
  endtask

  function automatic logic [7:0] data_flags();
    logic [7:0] f;
    do begin
      f = 8'($urandom_range(0, 127));
      if ($urandom_range(7) != 0) begin
        f[1:0] = 2'b00;
      end
    end while (f == FL_ACK_SYN || f == FL_SYN || f == FL_FIN || f == FL_FEND);
    return f;
  endfunction

  initial begin
    int          roll;
    int          waits;
    bit          held;
    bit          paused;
    logic [7:0]  f;
    logic [7:0]  lo;
    logic [7:0]  junk[$];
    int          cnt;

    led       = new();
    calm      = 0;
    hold_req  = 0;
    held      = 0;
    paused    = 0;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = 8'd0;
    in_tlast  = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed opening. Short three-byte datagrams lean on missing header bytes reading
    // as zero, which keeps every session step cheap.
    // File end before any name: silently ignored.
    send_datagram(FL_FEND, 8'd0, 8'd0, 0, -1, 0, 3);
    // Handshake acknowledgment: no reply; open request: acknowledged.
    send_datagram(FL_ACK_SYN, 8'd0, 8'd0, 0, -1, 0, 3);
    send_datagram(FL_SYN, 8'd0, 8'd0, 0, -1, 0, 3);
    // File name with a broken check word, then a good one that opens the file.
    send_datagram(FL_NAK_NAME, 8'd0, 8'd0, 0, -1, 1, 3);
    send_datagram(FL_NAK_NAME | 8'h03, 8'd0, 8'd0, 0, -1, 0, 3);
    // First in-order data with an all-ones payload byte, committed to the open file.
    send_datagram(DATA_PLAIN, 8'd1, 8'd0, 1, 255, 0, 0);
    // Duplicate of sequence zero with a zero-length field and one byte past the length.
    send_datagram(FL_ACK, 8'd0, 8'd0, 1, 0, 0, 0);
    // File end after a name: acknowledged and the file closes.
    send_datagram(FL_FEND, 8'd0, 8'd0, 0, -1, 0, 3);

    // Random traffic, mostly well-formed data with a realistic share of faults.
    while (led.bytes_seen < RANDOM_BYTES) begin
      if (!held && led.bytes_seen > 200) begin
        held     = 1;
        hold_req = 1;
      end
      if (!paused && led.bytes_seen > 350) begin
        paused = 1;
        drain();
        calm = 1;
      end
      if (calm && led.bytes_seen > 470) begin
        calm = 0;
      end
      lo   = ($urandom_range(7) == 0) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 8));
      roll = $urandom_range(99);
      if (roll < 58) begin
        send_datagram(data_flags(), lo,
                      ($urandom_range(3) != 0) ? led.next_seq() : 8'($urandom_range(0, 255)),
                      $urandom_range(0, 10), -1, 0, 0);
      end else if (roll < 68) begin
        send_datagram(data_flags(), lo, led.next_seq(), $urandom_range(0, 10), -1, 1, 0);
      end else if (roll < 76) begin
        send_datagram(FL_NAK_NAME | 8'($urandom_range(0, 127)), lo, 8'($urandom_range(0, 255)),
                      $urandom_range(0, 10), -1, $urandom_range(3) == 0, 0);
      end else if (roll < 81) begin
        send_datagram(FL_FEND, lo, 8'($urandom_range(0, 255)), $urandom_range(0, 3), -1,
                      $urandom_range(3) == 0, 0);
      end else if (roll < 86) begin
        send_datagram(($urandom_range(1) == 0) ? FL_SYN : FL_ACK_SYN, lo,
                      8'($urandom_range(0, 255)), $urandom_range(0, 3), -1, 0, 0);
      end else if (roll < 94) begin
        f = 8'($urandom_range(0, 255));
        if (f == FL_FIN) begin
          f = FL_SYN;
        end
        send_datagram(f, lo, 8'($urandom_range(0, 255)), 2, -1, $urandom_range(1) == 0,
                      $urandom_range(1, 4));
      end else begin
        // Pure noise of random length; only a closing request is kept out of it.
        cnt = $urandom_range(1, 8);
        junk.delete();
        for (int i = 0; i < cnt; i++) begin
          junk.insert(junk.size(), 8'($urandom_range(0, 255)));
        end
        if (cnt > 2 && junk[2] == FL_FIN) begin
          junk[2] = FL_FEND;
        end
        foreach (junk[i]) begin
          send_byte(junk[i], i == cnt - 1);
        end
      end
    end

    // A data datagram with a long tail of bytes past its declared length.
    drain();
    send_datagram(DATA_PLAIN, 8'($urandom_range(1, 8)), led.next_seq(), 60, -1, 0, 0);

    // Closing request, then beats that the closed session must swallow without a reply.
    drain();
    send_datagram(FL_FIN, 8'd0, 8'($urandom_range(0, 255)), 2, -1, 0, 0);
    for (int i = 0; i < 8; i++) begin
      send_byte(8'($urandom_range(0, 255)), $urandom_range(1) == 0);
    end
    in_tvalid <= 1'b0;

    waits = 0;
    while (led.due_replies.size() != 0 && waits < 5000) begin
      @(posedge clk);
      waits++;
    end
    repeat (10) @(posedge clk);
    if (led.due_replies.size() != 0) begin
      $error("%0d replies never arrived", led.due_replies.size());
      led.errors++;
    end

    $display("Run covered %0d beats in %0d datagrams and %0d checked replies (%0d commits),",
             led.bytes_seen, led.datagrams, led.replies_checked, led.commits);
    $display("including a long reply hold-off, a long tail past the length and a closed session.");
    if (led.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
